FILE: rtl/lfr_pkg.sv
// Package: shared types and constants for the length-prefixed frame receiver.
`timescale 1ns / 1ps

package lfr_pkg;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLOSE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ERR_ZERO_LEN       = 3'd0,
		ERR_TOO_SMALL      = 3'd1,
		ERR_TOO_LARGE      = 3'd2,
		ERR_CLOSED_HEADER  = 3'd3,
		ERR_CLOSED_PAYLOAD = 3'd4,
		ERR_TIMEOUT        = 3'd5
	} err_t;

	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

	localparam logic [31:0] RST_MIN_LENGTH    = 32'd1;
	localparam logic [31:0] RST_MAX_LENGTH    = 32'd16777216;
	localparam logic [31:0] RST_TIMEOUT_TICKS = 32'd1000000;

	typedef struct packed {
		logic [31:0] min_length;
		logic [31:0] max_length;
		logic [31:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic       is_error;
		logic [7:0] payload_byte;
		logic       last_of_message;
		err_t       error_code;
	} result_t;

endpackage

FILE: rtl/lfr_cfg.sv
// Configuration registers: minimum length, maximum length and timeout.
`timescale 1ns / 1ps

module lfr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	output lfr_pkg::cfg_t                   cfg
);
	import lfr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length    <= RST_MIN_LENGTH;
			cfg_q.max_length    <= RST_MAX_LENGTH;
			cfg_q.timeout_ticks <= RST_TIMEOUT_TICKS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_LENGTH:    cfg_q.min_length    <= cfg_data;
				CFG_MAX_LENGTH:    cfg_q.max_length    <= cfg_data;
				CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/lfr_core.sv
// Frame state: header assembly, length checks, payload count and frame timer.
`timescale 1ns / 1ps

module lfr_core #(
	parameter int unsigned HEADER_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  lfr_pkg::item_t   item,
	input  lfr_pkg::cfg_t    cfg,
	output logic             res_valid,
	output lfr_pkg::result_t res
);
	import lfr_pkg::*;

	localparam int unsigned CW = $clog2(HEADER_BYTES + 1);

	logic          in_payload_q,  in_payload_n;
	logic [CW-1:0] seen_q,        seen_n;
	logic [31:0]   acc_q,         acc_n;
	logic [31:0]   left_q,        left_n;
	logic          active_q,      active_n;
	logic [31:0]   elapsed_q,     elapsed_n;

	always_comb begin
		logic [31:0]   acc_shift;
		logic [CW-1:0] seen_inc;
		logic [31:0]   left_dec;
		logic [31:0]   elapsed_inc;
		logic          do_clear;
		logic          err;
		err_t          err_code;

		acc_shift   = {acc_q[23:0], item.data_byte};
		seen_inc    = seen_q + CW'(1);
		left_dec    = left_q - 32'd1;
		elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
		do_clear    = 1'b0;
		err         = 1'b0;
		err_code    = ERR_ZERO_LEN;

		in_payload_n = in_payload_q;
		seen_n       = seen_q;
		acc_n        = acc_q;
		left_n       = left_q;
		active_n     = active_q;
		elapsed_n    = elapsed_q;
		res_valid    = 1'b0;
		res          = '0;

		case (item.operation)
			OP_BYTE: begin
				if (!in_payload_q) begin
					if (!active_q) begin
						active_n  = 1'b1;
						elapsed_n = '0;
					end
					acc_n  = acc_shift;
					seen_n = seen_inc;
					if (seen_inc >= CW'(HEADER_BYTES)) begin
						if (acc_shift == 32'd0) begin
							err      = 1'b1;
							err_code = ERR_ZERO_LEN;
						end else if (acc_shift < cfg.min_length) begin
							err      = 1'b1;
							err_code = ERR_TOO_SMALL;
						end else if (acc_shift > cfg.max_length) begin
							err      = 1'b1;
							err_code = ERR_TOO_LARGE;
						end else begin
							in_payload_n = 1'b1;
							left_n       = acc_shift;
							seen_n       = '0;
							acc_n        = '0;
						end
					end
				end else begin
					left_n              = left_dec;
					res_valid           = 1'b1;
					res.payload_byte    = item.data_byte;
					res.last_of_message = (left_dec == 32'd0);
					do_clear            = (left_dec == 32'd0);
				end
			end
			OP_TICK: begin
				if (active_q) begin
					elapsed_n = elapsed_inc;
					if (elapsed_inc > cfg.timeout_ticks) begin
						err      = 1'b1;
						err_code = ERR_TIMEOUT;
					end
				end
			end
			OP_CLOSE: begin
				err      = 1'b1;
				err_code = in_payload_q ? ERR_CLOSED_PAYLOAD : ERR_CLOSED_HEADER;
			end
			default: ;
		endcase

		if (err) begin
			res_valid      = 1'b1;
			res.is_error   = 1'b1;
			res.error_code = err_code;
			do_clear       = 1'b1;
		end

		if (do_clear) begin
			in_payload_n = 1'b0;
			seen_n       = '0;
			acc_n        = '0;
			left_n       = '0;
			active_n     = 1'b0;
			elapsed_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			seen_q       <= '0;
			acc_q        <= '0;
			left_q       <= '0;
			active_q     <= 1'b0;
			elapsed_q    <= '0;
		end else if (advance) begin
			in_payload_q <= in_payload_n;
			seen_q       <= seen_n;
			acc_q        <= acc_n;
			left_q       <= left_n;
			active_q     <= active_n;
			elapsed_q    <= elapsed_n;
		end
	end

endmodule

FILE: rtl/lfr_out.sv
// Result register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module lfr_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  lfr_pkg::result_t res,
	output logic             can_load,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	output logic             m_axis_tuser
);
	import lfr_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_load      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {5'd0, res_q.error_code, res_q.payload_byte};
	assign m_axis_tlast  = res_q.last_of_message;
	assign m_axis_tuser  = res_q.is_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: rtl/length_prefixed_frame_receiver.sv
// Top level: length-prefixed frame receiver with input and result registers.
// One item is taken every cycle while the input side does not stall. An item
// passes an input register, is worked through the frame state combinationally
// and lands in the result register. The input side stalls only while the
// result register holds an item that the downstream side has not taken.
// Header bytes that pass the length checks, ticks within the timeout and
// ignored codes leave no result.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver #(
	parameter int unsigned HEADER_BYTES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  logic [1:0]                      s_axis_tuser,  // [1:0] operation
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [15:0]                     m_axis_tdata,  // [7:0] payload_byte,
	                                                       // [10:8] error_code
	output logic                            m_axis_tlast,  // last_of_message
	output logic                            m_axis_tuser,  // is_error
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);
	import lfr_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    can_load;
	logic    res_valid;
	result_t res;

	assign advance       = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation <= op_t'(s_axis_tuser);
			item_s1.data_byte <= s_axis_tdata;
		end
	end

	lfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfr_core #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	lfr_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res_valid),
		.res           (res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: rtl/lfr_checker.sv
// Checker: port-level properties of the frame receiver and its bind.
`timescale 1ns / 1ps

module lfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && m_axis_tdata[7:0] == 8'd0
			&& m_axis_tdata[10:8] <= 3'd5)
		else $error("malformed error item");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[10:8] == 3'd0)
		else $error("payload item carries an error code");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0)
		else $error("padding bits set");

endmodule

bind length_prefixed_frame_receiver lfr_checker u_lfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
